[hdl/pate_pkg.sv]
// Package for the positional array table engine.
// Holds the table sizes, command and status codes, the state machine type and
// the control struct that the top level broadcasts to the table cells.
`default_nettype none
package pate_pkg;

	// Table depth and the field widths that follow from it.
	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int POS_W  = 7;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 3;

	// Commands carried by a request transaction.
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 2'd0,
		CMD_DELETE  = 2'd1,
		CMD_SEARCH  = 2'd2,
		CMD_DISPLAY = 2'd3
	} cmd_t;

	// Status codes carried by a response transaction.
	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_EMPTY    = 3'd2,
		STAT_BADPOS   = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FIND,
		S_DISP
	} state_t;

	// What every cell does on the next clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	// Control broadcast to the row of cells.
	typedef struct packed {
		cell_op_t                  op;
		logic [POS_W-1:0]          pos;
		logic [CNT_W-1:0]          count;
		logic signed [DATA_W-1:0]  value;
	} cell_ctrl_t;

endpackage
`default_nettype wire

[hdl/pate_req_if.sv]
// Request channel of the table engine: command, value and position.
// Depends on pate_pkg for the field widths.
`default_nettype none
interface pate_req_if
	import pate_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [DATA_W-1:0]  value;
	logic [POS_W-1:0]          position;

	modport source (output valid, output cmd, output value, output position, input ready);
	modport sink (input valid, input cmd, input value, input position, output ready);
endinterface
`default_nettype wire

[hdl/pate_rsp_if.sv]
// Response channel of the table engine: status, data, index, count and last.
// Depends on pate_pkg for the field widths.
`default_nettype none
interface pate_rsp_if
	import pate_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [STAT_W-1:0]         status;
	logic signed [DATA_W-1:0]  data;
	logic [IDX_W-1:0]          index;
	logic [CNT_W-1:0]          count;
	logic                      last;

	modport source (output valid, output status, output data, output index, output count,
		output last, input ready);
	modport sink (input valid, input status, input data, input index, input count,
		input last, output ready);
endinterface
`default_nettype wire

[hdl/pate_cell.sv]
// One table cell: holds a single entry and loads from itself, its lower or
// upper neighbor, the head cell or the broadcast value. Depends on pate_pkg.
`default_nettype none
module pate_cell
	import pate_pkg::*;
(
	input  wire logic                      clk,
	input  wire cell_ctrl_t                ctrl,
	input  wire logic [IDX_W-1:0]          idx,
	input  wire logic signed [DATA_W-1:0]  lower,
	input  wire logic signed [DATA_W-1:0]  upper,
	input  wire logic signed [DATA_W-1:0]  head,
	output      logic signed [DATA_W-1:0]  entry,
	output      logic                      match,
	output      logic signed [DATA_W-1:0]  pick
);

	logic signed [DATA_W-1:0] entry_q;
	logic signed [DATA_W-1:0] entry_d;
	logic [POS_W-1:0]         idx_pos;
	logic [CNT_W-1:0]         idx_cnt;

	assign idx_pos = POS_W'(idx);
	assign idx_cnt = CNT_W'(idx);

	// Next value of the entry for each table operation.
	always_comb begin
		entry_d = entry_q;
		unique case (ctrl.op)
			CELL_HOLD: begin
				entry_d = entry_q;
			end
			CELL_INSERT: begin
				if (idx_pos == ctrl.pos) begin
					entry_d = ctrl.value;
				end else if (idx_pos > ctrl.pos) begin
					entry_d = lower;
				end
			end
			CELL_DELETE: begin
				if (idx_pos >= ctrl.pos) begin
					entry_d = upper;
				end
			end
			CELL_ROTATE: begin
				if (idx_cnt + CNT_W'(1) == ctrl.count) begin
					entry_d = head;
				end else begin
					entry_d = upper;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	// Entry storage; payload only, so no reset.
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	// Search match, limited to occupied cells, and the one-hot read for delete.
	assign entry = entry_q;
	assign match = (entry_q == ctrl.value) && (idx_cnt < ctrl.count);
	assign pick  = (idx_pos == ctrl.pos) ? entry_q : '0;

endmodule
`default_nettype wire

[hdl/positional_array_table_engine.sv]
// Top level of the positional array table engine: sequencer, fill count,
// response register and the row of pate_cell instances.
// Depends on pate_pkg, pate_req_if, pate_rsp_if and pate_cell.
//
// The block keeps a packed table of up to 64 signed 32-bit words in a row of
// cells that shift in parallel. Requests arrive on the req channel (cmd,
// value, position); responses leave on the rsp channel (status, data, index,
// count, last). A transaction is taken on a rising edge with valid and ready
// high.
//
// req.ready is high while the sequencer is idle. Insert and delete are done
// in S_EXEC, the state entered on acceptance, once the response register is
// free to take their response. Search registers a match vector from all
// cells in S_EXEC, then encodes the lowest hit in S_FIND.
// Display emits one response per stored word, one per cycle while the
// response register is free, by rotating the occupied cells through the
// head cell; the table order is restored after the last word. Insert, delete
// and any empty-table case respond from S_EXEC, search from S_FIND; the next
// request can be accepted once the sequencer is back in S_IDLE.
//
// The response register holds while rsp.ready is low and the sequencer waits
// for it to drain. Reset clears the fill count, the sequencer, the display
// counter and the response valid; the table contents are not cleared.
`default_nettype none
module positional_array_table_engine
	import pate_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	pate_req_if.sink    req,
	pate_rsp_if.source  rsp
);

	state_t                   state_q;
	state_t                   state_d;
	cmd_t                     cmd_q;
	logic signed [DATA_W-1:0] value_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         count_q;
	logic [DEPTH-1:0]         match_q;
	logic [IDX_W-1:0]         disp_q;

	logic                     rsp_valid_q;
	status_t                  rsp_status_q;
	logic signed [DATA_W-1:0] rsp_data_q;
	logic [IDX_W-1:0]         rsp_index_q;
	logic [CNT_W-1:0]         rsp_count_q;
	logic                     rsp_last_q;

	logic                     req_fire;
	logic                     slot_free;
	logic                     tbl_full;
	logic                     tbl_empty;
	logic                     disp_last;

	cell_ctrl_t               cell_ctrl;
	cell_op_t                 cell_op;
	logic                     load_rsp;
	logic                     cap_match;
	status_t                  nxt_status;
	logic signed [DATA_W-1:0] nxt_data;
	logic [IDX_W-1:0]         nxt_index;
	logic [CNT_W-1:0]         nxt_count;
	logic                     nxt_last;

	logic signed [DATA_W-1:0] entry_w [DEPTH];
	logic signed [DATA_W-1:0] lower_w [DEPTH];
	logic signed [DATA_W-1:0] upper_w [DEPTH];
	logic signed [DATA_W-1:0] pick_w  [DEPTH];
	logic [DEPTH-1:0]         match_w;
	logic signed [DATA_W-1:0] pick_or;
	logic [IDX_W-1:0]         find_idx;

	// Handshake and table status.
	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign tbl_full  = (count_q == CNT_W'(DEPTH));
	assign tbl_empty = (count_q == '0);
	assign disp_last = (CNT_W'(disp_q) + CNT_W'(1) == count_q);

	// Row of cells with neighbor links; the ends see zero.
	assign cell_ctrl = '{op: cell_op, pos: pos_q, count: count_q, value: value_q};

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_lo_end
			assign lower_w[g] = '0;
		end else begin : g_lo
			assign lower_w[g] = entry_w[g-1];
		end
		if (g == DEPTH - 1) begin : g_up_end
			assign upper_w[g] = '0;
		end else begin : g_up
			assign upper_w[g] = entry_w[g+1];
		end

		pate_cell u_cell (
			.clk   (clk),
			.ctrl  (cell_ctrl),
			.idx   (IDX_W'(g)),
			.lower (lower_w[g]),
			.upper (upper_w[g]),
			.head  (entry_w[0]),
			.entry (entry_w[g]),
			.match (match_w[g]),
			.pick  (pick_w[g])
		);
	end

	// Read of the entry at the delete position; at most one cell is nonzero.
	always_comb begin
		pick_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pick_or = pick_or | pick_w[i];
		end
	end

	// Lowest set bit of the registered match vector.
	always_comb begin
		find_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				find_idx = IDX_W'(i);
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (cmd_q)
					CMD_INSERT, CMD_DELETE: begin
						if (slot_free) begin
							state_d = S_IDLE;
						end
					end
					CMD_SEARCH: begin
						if (!tbl_empty) begin
							state_d = S_FIND;
						end else if (slot_free) begin
							state_d = S_IDLE;
						end
					end
					CMD_DISPLAY: begin
						if (!tbl_empty) begin
							state_d = S_DISP;
						end else if (slot_free) begin
							state_d = S_IDLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_FIND: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_DISP: begin
				if (slot_free && disp_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: cell operation and the next response.
	always_comb begin
		cell_op    = CELL_HOLD;
		load_rsp   = 1'b0;
		cap_match  = 1'b0;
		nxt_status = STAT_OK;
		nxt_data   = '0;
		nxt_index  = '0;
		nxt_count  = count_q;
		nxt_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				load_rsp = 1'b0;
			end
			S_EXEC: begin
				unique case (cmd_q)
					CMD_INSERT: begin
						load_rsp = slot_free;
						if (tbl_full) begin
							nxt_status = STAT_FULL;
						end else if (pos_q > POS_W'(count_q)) begin
							nxt_status = STAT_BADPOS;
						end else begin
							nxt_index = pos_q[IDX_W-1:0];
							nxt_count = count_q + CNT_W'(1);
							if (slot_free) begin
								cell_op = CELL_INSERT;
							end
						end
					end
					CMD_DELETE: begin
						load_rsp = slot_free;
						if (tbl_empty) begin
							nxt_status = STAT_EMPTY;
						end else if (pos_q >= POS_W'(count_q)) begin
							nxt_status = STAT_BADPOS;
						end else begin
							nxt_data  = pick_or;
							nxt_index = pos_q[IDX_W-1:0];
							nxt_count = count_q - CNT_W'(1);
							if (slot_free) begin
								cell_op = CELL_DELETE;
							end
						end
					end
					CMD_SEARCH: begin
						if (tbl_empty) begin
							load_rsp   = slot_free;
							nxt_status = STAT_EMPTY;
						end else begin
							cap_match = 1'b1;
						end
					end
					CMD_DISPLAY: begin
						if (tbl_empty) begin
							load_rsp   = slot_free;
							nxt_status = STAT_EMPTY;
						end
					end
					default: begin
						load_rsp = 1'b0;
					end
				endcase
			end
			S_FIND: begin
				load_rsp = slot_free;
				if (|match_q) begin
					nxt_index = find_idx;
				end else begin
					nxt_status = STAT_NOTFOUND;
				end
			end
			S_DISP: begin
				load_rsp  = slot_free;
				nxt_data  = entry_w[0];
				nxt_index = disp_q;
				nxt_last  = disp_last;
				if (slot_free) begin
					cell_op = CELL_ROTATE;
				end
			end
			default: begin
				load_rsp = 1'b0;
			end
		endcase
	end

	// Control registers: state, fill count, display counter, response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			disp_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_rsp) begin
				count_q <= nxt_count;
			end
			if (req_fire) begin
				disp_q <= '0;
			end else if (state_q == S_DISP && slot_free) begin
				disp_q <= disp_q + IDX_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: captured request, match vector and response fields.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q   <= cmd_t'(req.cmd);
			value_q <= req.value;
			pos_q   <= req.position;
		end
		if (cap_match) begin
			match_q <= match_w;
		end
		if (load_rsp) begin
			rsp_status_q <= nxt_status;
			rsp_data_q   <= nxt_data;
			rsp_index_q  <= nxt_index;
			rsp_count_q  <= nxt_count;
			rsp_last_q   <= nxt_last;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.index  = rsp_index_q;
	assign rsp.count  = rsp_count_q;
	assign rsp.last   = rsp_last_q;

endmodule
`default_nettype wire

[bench/tb_positional_array_table_engine.sv]
// Self-checking testbench for positional_array_table_engine: table commands
// go in on the request channel, responses are checked against a local table.
// Depends on pate_pkg, pate_req_if, pate_rsp_if and the engine RTL.
module tb_positional_array_table_engine;
	import pate_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Kinds of entries in the pending command queue.
	typedef enum logic [1:0] {
		PEND_CMD,
		PEND_DRAIN,
		PEND_LONG_HOLD
	} pend_kind_t;

	// How the position of a command is chosen when it is launched.
	typedef enum logic [1:0] {
		POS_FIXED,
		POS_IN_RANGE,
		POS_AT_FILL,
		POS_WILD
	} pos_pick_t;

	typedef struct {
		pend_kind_t                kind;
		cmd_t                      cmd;
		logic signed [DATA_W-1:0]  value;
		logic [POS_W-1:0]          position;
		pos_pick_t                 pos_pick;
		bit                        hit_pick;
	} pend_cmd_t;

	typedef struct {
		status_t                   status;
		logic signed [DATA_W-1:0]  data;
		logic [IDX_W-1:0]          index;
		logic [CNT_W-1:0]          count;
		logic                      last;
	} tbl_rsp_t;

	localparam int LONG_HOLD_CYCLES = 400;
	localparam int N_ITEMS = 420;

	logic clk;
	logic arst_n;

	pate_req_if req_ch ();
	pate_rsp_if rsp_ch ();

	positional_array_table_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Local copy of the table and the responses it predicts.
	logic signed [DATA_W-1:0] tbl_words [DEPTH];
	int tbl_fill = 0;
	tbl_rsp_t rsp_exp_q [$];
	pend_cmd_t cmd_pend_q [$];
	int mismatches = 0;
	int n_items = 0;

	// Sender state and the handoff that starts a long receiver hold.
	int burst_left = 1;
	int gap_left = 0;
	logic hold_toggle = 1'b0;

	always #2 clk = ~clk;

	function automatic void push_rsp(status_t st, logic signed [DATA_W-1:0] data, int idx,
		bit last);
		tbl_rsp_t r;
		r.status = st;
		r.data = data;
		r.index = IDX_W'(idx);
		r.count = CNT_W'(tbl_fill);
		r.last = last;
		rsp_exp_q.push_back(r);
	endfunction

	// Applies one accepted command to the local table and queues its responses.
	function automatic void predict_table_op(cmd_t op, logic signed [DATA_W-1:0] word,
		logic [POS_W-1:0] pos);
		int i;
		int hit;
		case (op)
			CMD_INSERT: begin
				if (tbl_fill >= DEPTH) begin
					push_rsp(STAT_FULL, '0, 0, 1'b1);
				end else if (int'(pos) > tbl_fill) begin
					push_rsp(STAT_BADPOS, '0, 0, 1'b1);
				end else begin
					for (i = tbl_fill; i > int'(pos); i--)
						tbl_words[i] = tbl_words[i-1];
					tbl_words[pos] = word;
					tbl_fill++;
					push_rsp(STAT_OK, '0, int'(pos), 1'b1);
				end
			end
			CMD_DELETE: begin
				if (tbl_fill == 0) begin
					push_rsp(STAT_EMPTY, '0, 0, 1'b1);
				end else if (int'(pos) >= tbl_fill) begin
					push_rsp(STAT_BADPOS, '0, 0, 1'b1);
				end else begin
					word = tbl_words[pos];
					for (i = int'(pos); i + 1 < tbl_fill; i++)
						tbl_words[i] = tbl_words[i+1];
					tbl_fill--;
					push_rsp(STAT_OK, word, int'(pos), 1'b1);
				end
			end
			CMD_SEARCH: begin
				hit = -1;
				for (i = tbl_fill - 1; i >= 0; i--)
					if (tbl_words[i] == word)
						hit = i;
				if (tbl_fill == 0)
					push_rsp(STAT_EMPTY, '0, 0, 1'b1);
				else if (hit < 0)
					push_rsp(STAT_NOTFOUND, '0, 0, 1'b1);
				else
					push_rsp(STAT_OK, '0, hit, 1'b1);
			end
			default: begin
				if (tbl_fill == 0)
					push_rsp(STAT_EMPTY, '0, 0, 1'b1);
				for (i = 0; i < tbl_fill; i++)
					push_rsp(STAT_OK, tbl_words[i], i, i + 1 == tbl_fill);
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
		logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Driver: predicts each accepted transaction, then launches the next one
	// in bursts separated by random gaps.
	always @(posedge clk) begin
		pend_cmd_t nxt;
		bit launch;
		int lim;
		logic [POS_W-1:0] pos;
		logic signed [DATA_W-1:0] word;
		launch = 1'b0;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_table_op(cmd_t'(req_ch.cmd), req_ch.value, req_ch.position);
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (cmd_pend_q.size() != 0) begin
					case (cmd_pend_q[0].kind)
						PEND_DRAIN: begin
							if (rsp_exp_q.size() == 0)
								void'(cmd_pend_q.pop_front());
						end
						PEND_LONG_HOLD: begin
							hold_toggle <= ~hold_toggle;
							void'(cmd_pend_q.pop_front());
						end
						default: launch = 1'b1;
					endcase
				end
				if (launch) begin
					nxt = cmd_pend_q.pop_front();
					// Positions and search hits are resolved against the current table.
					case (nxt.pos_pick)
						POS_IN_RANGE: begin
							lim = (nxt.cmd == CMD_INSERT) ? tbl_fill
								: ((tbl_fill == 0) ? 0 : tbl_fill - 1);
							pos = POS_W'($urandom_range(0, lim));
						end
						POS_AT_FILL: pos = POS_W'(tbl_fill);
						POS_WILD:    pos = POS_W'($urandom_range(0, 127));
						default:     pos = nxt.position;
					endcase
					word = nxt.value;
					if (nxt.hit_pick && tbl_fill != 0)
						word = tbl_words[$urandom_range(0, tbl_fill - 1)];
					req_ch.valid <= 1'b1;
					req_ch.cmd <= nxt.cmd;
					req_ch.value <= word;
					req_ch.position <= pos;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern that changes mode now and then, plus a long
	// hold whenever the driver flips the hold toggle.
	always @(posedge clk) begin
		logic hold_seen;
		int hold_left;
		int mode;
		int mode_left;
		int cyc;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_seen = hold_toggle;
			hold_left = 0;
			mode = 0;
			mode_left = 0;
			cyc = 0;
		end else begin
			cyc++;
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(32, 200);
			end else begin
				mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= (cyc % 5 != 0);
				endcase
			end
		end
	end

	// Monitor: each response transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		tbl_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_exp_q.size() == 0) begin
				$display("%0t: unexpected response, status %0d data %h index %0d count %0d last %b",
					$time, rsp_ch.status, rsp_ch.data, rsp_ch.index, rsp_ch.count,
					rsp_ch.last);
				mismatches++;
			end else begin
				want = rsp_exp_q.pop_front();
				check_field("status", want.status, rsp_ch.status);
				check_field("data", want.data, rsp_ch.data);
				check_field("index", want.index, rsp_ch.index);
				check_field("count", want.count, rsp_ch.count);
				check_field("last", want.last, rsp_ch.last);
			end
		end
	end

	task automatic add_cmd(cmd_t c, logic signed [DATA_W-1:0] v, pos_pick_t pp,
		logic [POS_W-1:0] p, bit hit);
		pend_cmd_t it;
		it.kind = PEND_CMD;
		it.cmd = c;
		it.value = v;
		it.pos_pick = pp;
		it.position = p;
		it.hit_pick = hit;
		cmd_pend_q.push_back(it);
		n_items++;
	endtask

	task automatic add_marker(pend_kind_t k);
		pend_cmd_t it;
		it.kind = k;
		it.cmd = CMD_DISPLAY;
		it.value = '0;
		it.pos_pick = POS_FIXED;
		it.position = '0;
		it.hit_pick = 1'b0;
		cmd_pend_q.push_back(it);
	endtask

	function automatic logic signed [DATA_W-1:0] rand_word();
		if ($urandom_range(0, 9) < 3)
			return DATA_W'(int'($urandom_range(0, 4)) - 2);
		return $urandom;
	endfunction

	// Stimulus, reset and end of test.
	initial begin
		int phase;
		int plen;
		int ins_pct;
		int del_pct;
		int r;
		int pp_r;
		pos_pick_t pp;
		cmd_t c;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_INSERT;
		req_ch.value = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;

		// Directed: empty table, the value extremes, bad positions and duplicates.
		add_cmd(CMD_DISPLAY, 32'sd0, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_DELETE, 32'sd0, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_SEARCH, 32'sd0, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_INSERT, 32'sd5, POS_FIXED, 7'd1, 1'b0);
		add_cmd(CMD_INSERT, 32'h7fffffff, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_INSERT, 32'h80000000, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_INSERT, -32'sd1, POS_FIXED, 7'd2, 1'b0);
		add_cmd(CMD_INSERT, 32'sd0, POS_FIXED, 7'd1, 1'b0);
		add_cmd(CMD_INSERT, 32'sd9, POS_FIXED, 7'd127, 1'b0);
		add_cmd(CMD_INSERT, 32'sd9, POS_FIXED, 7'd5, 1'b0);
		add_cmd(CMD_SEARCH, 32'h80000000, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_SEARCH, -32'sd1, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_SEARCH, 32'sd12345, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_INSERT, -32'sd1, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_SEARCH, -32'sd1, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_DISPLAY, 32'sd0, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_DELETE, 32'sd0, POS_FIXED, 7'd5, 1'b0);
		add_cmd(CMD_DELETE, 32'sd0, POS_FIXED, 7'd127, 1'b0);
		add_cmd(CMD_DELETE, 32'sd0, POS_FIXED, 7'd4, 1'b0);
		add_cmd(CMD_DELETE, 32'sd0, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_DELETE, 32'sd0, POS_FIXED, 7'd1, 1'b0);
		add_cmd(CMD_DISPLAY, 32'sd0, POS_FIXED, 7'd0, 1'b0);
		add_marker(PEND_DRAIN);

		// Fill to the top, then hit the full table from every side.
		repeat (70)
			add_cmd(CMD_INSERT, rand_word(), POS_IN_RANGE, 7'd0, 1'b0);
		add_cmd(CMD_DISPLAY, $urandom, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_INSERT, $urandom, POS_FIXED, 7'd64, 1'b0);
		add_cmd(CMD_INSERT, $urandom, POS_FIXED, 7'd127, 1'b0);
		add_cmd(CMD_DELETE, $urandom, POS_AT_FILL, 7'd0, 1'b0);
		add_cmd(CMD_DELETE, $urandom, POS_FIXED, 7'd63, 1'b0);
		add_cmd(CMD_INSERT, $urandom, POS_FIXED, 7'd63, 1'b0);
		add_marker(PEND_LONG_HOLD);
		add_cmd(CMD_SEARCH, $urandom, POS_FIXED, 7'd0, 1'b1);
		add_cmd(CMD_DELETE, $urandom, POS_FIXED, 7'd0, 1'b0);
		add_cmd(CMD_SEARCH, $urandom, POS_FIXED, 7'd0, 1'b0);

		// Random phases that grow, shrink or churn the table.
		while (n_items < N_ITEMS) begin
			phase = $urandom_range(0, 2);
			plen = $urandom_range(20, 60);
			ins_pct = (phase == 0) ? 60 : (phase == 1) ? 10 : 35;
			del_pct = (phase == 0) ? 10 : (phase == 1) ? 65 : 35;
			repeat (plen) begin
				r = $urandom_range(0, 99);
				if (r < ins_pct)
					c = CMD_INSERT;
				else if (r < ins_pct + del_pct)
					c = CMD_DELETE;
				else if (r < 94)
					c = CMD_SEARCH;
				else
					c = CMD_DISPLAY;
				pp_r = $urandom_range(0, 99);
				pp = (pp_r < 85) ? POS_IN_RANGE : (pp_r < 92) ? POS_AT_FILL : POS_WILD;
				add_cmd(c, rand_word(), pp, 7'd0, $urandom_range(0, 9) < 6);
			end
			if ($urandom_range(0, 3) == 0)
				add_marker(PEND_DRAIN);
			if (n_items > 250 && n_items < 320)
				add_marker(PEND_LONG_HOLD);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_pend_q.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (rsp_exp_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && rsp_exp_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
